// File: src/imu_serial_frame_decoder_top_defines.svh
// Assertion macros shared by the serial frame decoder modules.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISFD_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISFD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/isfd_pkg.sv
// Shared types, constants and decode helpers for the serial frame decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package isfd_pkg;

	localparam int FRAME_BYTES = 11;
	localparam int STORE_DEPTH = FRAME_BYTES - 2;
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;

	localparam logic [1:0] KIND_ACCEL = 2'd0;
	localparam logic [1:0] KIND_RATE = 2'd1;
	localparam logic [1:0] KIND_ANGLE = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam int GRAVITY_W = 21;
	localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 21'd642253;
	localparam logic [GRAVITY_W-1:0] RATE_SCALE = 21'd4000;
	localparam logic [GRAVITY_W-1:0] ANGLE_SCALE = 21'd360;
	localparam int ACCEL_SHIFT = 11;

	// (raw << 16) / 340 equals |raw| * 16384 / 85; the reciprocal below is
	// exact for every 16-bit magnitude after a shift of 37 - 14 bits.
	localparam logic [30:0] DIV85_MUL = 31'd1616928865;
	localparam int DIV85_SHIFT = 23;
	localparam logic [24:0] TEMP_OFFSET = 25'd2394030;

	localparam int VALUE_W = 28;
	localparam int TEMP_W = 25;
	localparam int PROD_W = 38;
	localparam int TPROD_W = 48;

	localparam int ADDR_W = 3;
	localparam logic REG_GRAVITY = 1'b0;

	typedef struct packed {
		logic [7:0]         ftype;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
		logic signed [15:0] raw_t;
	} frame_t;

	function automatic logic [1:0] kind_of(input logic [7:0] ftype);
		logic [1:0] k;
		case (ftype)
			TYPE_ACCEL: k = KIND_ACCEL;
			TYPE_RATE:  k = KIND_RATE;
			TYPE_ANGLE: k = KIND_ANGLE;
			default:    k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

// File: src/imu_serial_frame_decoder_top.sv
// Decodes 11-byte inertial sensor frames from a serial byte stream: one byte is
// taken per transfer; one byte per clock cycle is sustained with no gaps while the
// frame register can hand its frame on. A frame whose checksum matches yields one
// result through a frame register, a multiplier stage and a result register;
// the byte side keeps running while a result waits, until the frame register
// is stalled. Frames with a bad checksum give no result. The gravity scale
// register at byte address 0 may be written only while the block is idle.
// Depends on isfd_pkg, isfd_regs, isfd_framer and isfd_scaler.
`timescale 1ns / 1ps

module imu_serial_frame_decoder_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [isfd_pkg::ADDR_W-1:0]             paddr,
	input  logic [31:0]                             pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [7:0]                              rx_byte,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [1:0]                              frame_kind,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_x,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_y,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_z,
	output logic signed [isfd_pkg::TEMP_W-1:0]      temperature_q16
);

	logic [isfd_pkg::GRAVITY_W-1:0] gravity;
	logic                           frm_valid;
	logic                           frm_ready;
	isfd_pkg::frame_t               frm;

	isfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gravity (gravity)
	);

	isfd_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	isfd_scaler u_scaler (
		.clk             (clk),
		.arst_n          (arst_n),
		.gravity         (gravity),
		.frm_valid       (frm_valid),
		.frm_ready       (frm_ready),
		.frm             (frm),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_kind      (frame_kind),
		.value_x         (value_x),
		.value_y         (value_y),
		.value_z         (value_z),
		.temperature_q16 (temperature_q16)
	);

endmodule

// File: src/isfd_regs.sv
// Configuration register file on an APB-style port: holds the gravity scale.
// Depends on isfd_pkg for widths, register index and reset value.
`timescale 1ns / 1ps

module isfd_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [isfd_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output logic [isfd_pkg::GRAVITY_W-1:0]      gravity
);

	logic                              reg_idx;
	logic [isfd_pkg::GRAVITY_W-1:0]    gravity_q;

	assign reg_idx = paddr[isfd_pkg::ADDR_W-1];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= isfd_pkg::GRAVITY_RESET;
		end else if (psel && penable && pwrite && reg_idx == isfd_pkg::REG_GRAVITY) begin
			gravity_q <= pwdata[isfd_pkg::GRAVITY_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == isfd_pkg::REG_GRAVITY) begin
			prdata = {(32 - isfd_pkg::GRAVITY_W)'(0), gravity_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign gravity = gravity_q;

endmodule

// File: src/isfd_framer.sv
// Byte-level frame hunter: finds the header, collects the frame, checks the sum.
// Depends on isfd_pkg; hands each good frame on as a frame_t with valid/ready.
`timescale 1ns / 1ps
`include "imu_serial_frame_decoder_top_defines.svh"

module isfd_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              frm_valid,
	input  logic              frm_ready,
	output isfd_pkg::frame_t  frm
);

	logic [isfd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 store_q [isfd_pkg::STORE_DEPTH];
	logic                       frm_valid_s1;
	isfd_pkg::frame_t           frm_s1;
	logic                       fire;
	logic                       collecting;
	logic                       at_last;
	logic [isfd_pkg::POS_W-1:0] widx;

	assign in_ready = !frm_valid_s1 || frm_ready;
	assign fire = in_valid && in_ready;
	assign collecting = (pos_q != '0) && (pos_q < isfd_pkg::LAST_POS);
	assign at_last = (pos_q == isfd_pkg::LAST_POS);
	assign widx = pos_q - isfd_pkg::POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= isfd_pkg::HEADER_BYTE;
		end else if (fire) begin
			if (pos_q == '0) begin
				if (rx_byte == isfd_pkg::HEADER_BYTE) begin
					pos_q <= isfd_pkg::POS_W'(1);
					sum_q <= isfd_pkg::HEADER_BYTE;
				end
			end else if (at_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + isfd_pkg::POS_W'(1);
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < isfd_pkg::STORE_DEPTH; i++) begin
			if (fire && collecting && widx == isfd_pkg::POS_W'(i)) begin
				store_q[i] <= rx_byte;
			end
		end
	end

	// A frame whose checksum matches is copied out, so the store is free
	// for the next frame at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_s1 <= 1'b0;
		end else if (fire && at_last && rx_byte == sum_q) begin
			frm_valid_s1 <= 1'b1;
		end else if (frm_ready) begin
			frm_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && at_last && rx_byte == sum_q) begin
			frm_s1.ftype <= store_q[0];
			frm_s1.raw_x <= {store_q[2], store_q[1]};
			frm_s1.raw_y <= {store_q[4], store_q[3]};
			frm_s1.raw_z <= {store_q[6], store_q[5]};
			frm_s1.raw_t <= {store_q[8], store_q[7]};
		end
	end

	assign frm_valid = frm_valid_s1;
	assign frm = frm_s1;

	`ISFD_ASSERT_NEXT(a_hunt_stays, clk, arst_n,
		fire && pos_q == '0 && rx_byte != isfd_pkg::HEADER_BYTE, pos_q == '0,
		"framer left hunting on a non-header byte")
	`ISFD_ASSERT_NEXT(a_last_returns, clk, arst_n,
		fire && at_last, pos_q == '0,
		"framer did not return to hunting after the checksum byte")
	`ISFD_ASSERT_NEXT(a_good_frame, clk, arst_n,
		fire && at_last && rx_byte == sum_q, frm_valid_s1,
		"frame with a matching checksum was not passed on")

endmodule

// File: src/isfd_scaler.sv
// Two-stage scaling datapath: registered products, then shift, sign and offset.
// Depends on isfd_pkg; takes frame_t items from the framer, drives the result port.
`timescale 1ns / 1ps
`include "imu_serial_frame_decoder_top_defines.svh"

module isfd_scaler (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [isfd_pkg::GRAVITY_W-1:0]          gravity,
	input  logic                                    frm_valid,
	output logic                                    frm_ready,
	input  isfd_pkg::frame_t                        frm,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [1:0]                              frame_kind,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_x,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_y,
	output logic signed [isfd_pkg::VALUE_W-1:0]     value_z,
	output logic signed [isfd_pkg::TEMP_W-1:0]      temperature_q16
);

	logic                                   v_s2;
	logic                                   v_s3;
	logic                                   adv2;
	logic                                   adv3;
	logic [1:0]                             kind;
	logic [isfd_pkg::GRAVITY_W-1:0]         coef;
	logic signed [isfd_pkg::PROD_W-1:0]     coef_ext;
	logic [16:0]                            tmag;
	logic [1:0]                             kind_s2;
	logic signed [isfd_pkg::PROD_W-1:0]     px_s2;
	logic signed [isfd_pkg::PROD_W-1:0]     py_s2;
	logic signed [isfd_pkg::PROD_W-1:0]     pz_s2;
	logic [isfd_pkg::TPROD_W-1:0]           pt_s2;
	logic                                   tneg_s2;
	logic signed [isfd_pkg::PROD_W-1:0]     sx;
	logic signed [isfd_pkg::PROD_W-1:0]     sy;
	logic signed [isfd_pkg::PROD_W-1:0]     sz;
	logic [isfd_pkg::TEMP_W-1:0]            tq;
	logic [isfd_pkg::TEMP_W-1:0]            tval;
	logic [1:0]                             kind_s3;
	logic signed [isfd_pkg::VALUE_W-1:0]    x_s3;
	logic signed [isfd_pkg::VALUE_W-1:0]    y_s3;
	logic signed [isfd_pkg::VALUE_W-1:0]    z_s3;
	logic signed [isfd_pkg::TEMP_W-1:0]     t_s3;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign frm_ready = adv2;

	// One scale factor per frame kind; an unknown kind multiplies by zero.
	always_comb begin
		kind = isfd_pkg::kind_of(frm.ftype);
		case (kind)
			isfd_pkg::KIND_ACCEL: coef = gravity;
			isfd_pkg::KIND_RATE:  coef = isfd_pkg::RATE_SCALE;
			isfd_pkg::KIND_ANGLE: coef = isfd_pkg::ANGLE_SCALE;
			default:              coef = '0;
		endcase
		coef_ext = isfd_pkg::PROD_W'($signed({1'b0, coef}));
		tmag = frm.raw_t[15] ? (17'd0 - 17'(frm.raw_t)) : 17'(frm.raw_t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= frm_valid;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && frm_valid) begin
			kind_s2 <= kind;
			px_s2 <= isfd_pkg::PROD_W'(frm.raw_x) * coef_ext;
			py_s2 <= isfd_pkg::PROD_W'(frm.raw_y) * coef_ext;
			pz_s2 <= isfd_pkg::PROD_W'(frm.raw_z) * coef_ext;
			pt_s2 <= isfd_pkg::TPROD_W'(tmag) * isfd_pkg::TPROD_W'(isfd_pkg::DIV85_MUL);
			tneg_s2 <= frm.raw_t[15];
		end
	end

	// Acceleration products are floored by an arithmetic shift; the
	// temperature quotient is truncated toward zero, then signed.
	always_comb begin
		if (kind_s2 == isfd_pkg::KIND_ACCEL) begin
			sx = px_s2 >>> isfd_pkg::ACCEL_SHIFT;
			sy = py_s2 >>> isfd_pkg::ACCEL_SHIFT;
			sz = pz_s2 >>> isfd_pkg::ACCEL_SHIFT;
		end else begin
			sx = px_s2;
			sy = py_s2;
			sz = pz_s2;
		end
		tq = isfd_pkg::TEMP_W'(pt_s2 >> isfd_pkg::DIV85_SHIFT);
		tval = (tneg_s2 ? (isfd_pkg::TEMP_W'(0) - tq) : tq) + isfd_pkg::TEMP_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			kind_s3 <= kind_s2;
			x_s3 <= sx[isfd_pkg::VALUE_W-1:0];
			y_s3 <= sy[isfd_pkg::VALUE_W-1:0];
			z_s3 <= sz[isfd_pkg::VALUE_W-1:0];
			t_s3 <= tval;
		end
	end

	assign out_valid = v_s3;
	assign frame_kind = kind_s3;
	assign value_x = x_s3;
	assign value_y = y_s3;
	assign value_z = z_s3;
	assign temperature_q16 = t_s3;

	`ISFD_ASSERT_SAME(a_other_zero, clk, arst_n,
		v_s3 && kind_s3 == isfd_pkg::KIND_OTHER, x_s3 == '0 && y_s3 == '0 && z_s3 == '0,
		"unknown frame type produced nonzero axis values")
	`ISFD_ASSERT_NEXT(a_take_frame, clk, arst_n,
		frm_valid && frm_ready, v_s2,
		"accepted frame did not reach the product stage")
	`ISFD_ASSERT_NEXT(a_hold_s2, clk, arst_n,
		v_s2 && !adv3, v_s2,
		"product stage dropped an item while the output was stalled")

endmodule
